>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh: shared assertion macros
// Clocked implication checks, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/rkr_pkg.sv
// ----------------------------------------------------------------------------
// rkr_pkg: shared types and constants
// Word layouts, status codes and the divider control struct.
// ----------------------------------------------------------------------------
package rkr_pkg;
	localparam int unsigned KeyBits = 32;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOFACTOR  = 2'd1,
		ST_NOINVERSE = 2'd2
	} status_t;

	typedef struct packed {
		logic [KeyBits-1:0] modulus;
		logic [KeyBits-1:0] public_exponent;
		logic [KeyBits-1:0] ciphertext;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] factor_p;
		logic [30:0] factor_q;
		logic [31:0] private_exponent;
		logic [31:0] plaintext;
	} out_word_t;

	// divider request: 64-bit dividend, 32-bit divisor
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
		logic [31:0] remainder;
	} div_rsp_t;
endpackage

>>> rtl/rkr_if.sv
// ----------------------------------------------------------------------------
// rkr_in_if / rkr_out_if: valid-ready channels
// Carry one input or result word per handshake.
// ----------------------------------------------------------------------------
interface rkr_in_if;
	logic             valid;
	logic             ready;
	rkr_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rkr_out_if;
	logic              valid;
	logic              ready;
	rkr_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rkr_div.sv
// ----------------------------------------------------------------------------
// rkr_div: radix-2 restoring divider
// 64 by 32 bit unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rkr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rkr_pkg::div_req_t req,
	output rkr_pkg::div_rsp_t rsp
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [33:0] diff;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign diff    = {1'b0, shifted} - {2'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q[31:0];
endmodule

>>> rtl/rsa_key_recovery_decrypt.sv
// ----------------------------------------------------------------------------
// rsa_key_recovery_decrypt: factor a small RSA key and decrypt one word
// Trial division, extended Euclid and square-and-multiply, all sharing one
// serial 64/32 divider under a sequencer.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// in_ch    | in  | modulus, public_exponent, ciphertext
// out_ch   | out | status, factor_p, factor_q, private_exponent, plaintext
//
// One word at a time; in_ch.ready is high only while the sequencer is idle.
// Every divide goes through the shared divider, so run time grows with the number
// of candidates tried, Euclid steps and exponent bits.
// Reset (arst_n low) drops any word in flight; a result is held until taken.
module rsa_key_recovery_decrypt (
	input logic clk,
	input logic arst_n,
	rkr_in_if.sink    in_ch,
	rkr_out_if.source out_ch
);
	typedef enum logic [3:0] {
		S_IDLE, S_TRY, S_TRY_W, S_TOT, S_EINIT, S_EINIT_W, S_EUC, S_EUC_W,
		S_FIX, S_PBASE, S_PBASE_W, S_PMUL, S_PMUL_W, S_PSQR, S_PSQR_W, S_OUT
	} state_t;

	state_t state_q;
	rkr_pkg::div_req_t req;
	rkr_pkg::div_rsp_t rsp;

	logic [31:0] n_q, e_q, c_q;
	logic [16:0] i_q;          // trial divisor
	logic [15:0] p_q;
	logic [30:0] q_q;
	logic [31:0] tot_q;
	logic [31:0] r0_q, r1_q;
	logic signed [33:0] t0_q, t1_q;
	logic [31:0] acc_q, base_q, expo_q;
	logic [33:0] isq;
	logic signed [67:0] qt;

	assign isq = {17'b0, i_q} * {17'b0, i_q};
	assign qt  = $signed({2'b0, rsp.quotient[31:0]}) * t1_q;

	rkr_div u_div (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// issue the divide for each waiting state from its launch state
	always_comb begin
		req = '0;
		unique case (state_q)
			S_TRY: begin
				req.start = (isq <= {2'b0, n_q});
				req.dividend = {32'b0, n_q};
				req.divisor = {15'b0, i_q};
			end
			S_EINIT: begin
				req.start = 1'b1;
				req.dividend = {32'b0, e_q};
				req.divisor = tot_q;
			end
			S_EUC: begin
				req.start = (r1_q != 32'd0);
				req.dividend = {32'b0, r0_q};
				req.divisor = r1_q;
			end
			S_PBASE: begin
				req.start = 1'b1;
				req.dividend = {32'b0, c_q};
				req.divisor = n_q;
			end
			S_PMUL: begin
				req.start = expo_q[0];
				req.dividend = {32'b0, acc_q} * {32'b0, base_q};
				req.divisor = n_q;
			end
			S_PSQR: begin
				req.start = 1'b1;
				req.dividend = {32'b0, base_q} * {32'b0, base_q};
				req.divisor = n_q;
			end
			default: req = '0;
		endcase
	end

	assign in_ch.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_ch.valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					n_q <= in_ch.data.modulus;
					e_q <= in_ch.data.public_exponent;
					c_q <= in_ch.data.ciphertext;
					i_q <= 17'd2;
					out_ch.data <= '0;
					state_q <= S_TRY;
				end
				S_TRY: begin
					// past sqrt(n): no factor
					if (isq > {2'b0, n_q}) begin
						out_ch.data.status <= rkr_pkg::ST_NOFACTOR;
						state_q <= S_OUT;
					end else begin
						state_q <= S_TRY_W;
					end
				end
				S_TRY_W: if (rsp.done) begin
					if (rsp.remainder == 32'd0) begin
						p_q <= i_q[15:0];
						q_q <= rsp.quotient[30:0];
						state_q <= S_TOT;
					end else begin
						i_q <= i_q + 17'd1;
						state_q <= S_TRY;
					end
				end
				S_TOT: begin
					// (p-1)(q-1) < 2^32 since p*q = n
					tot_q <= 32'({16'b0, p_q - 16'd1} * {1'b0, q_q - 31'd1});
					state_q <= S_EINIT;
				end
				S_EINIT: begin
					if (tot_q < 32'd2) begin
						out_ch.data.status <= rkr_pkg::ST_NOINVERSE;
						state_q <= S_OUT;
					end else begin
						state_q <= S_EINIT_W;
					end
				end
				S_EINIT_W: if (rsp.done) begin
					r0_q <= tot_q;
					r1_q <= rsp.remainder;
					t0_q <= '0;
					t1_q <= 34'sd1;
					state_q <= S_EUC;
				end
				S_EUC: begin
					state_q <= (r1_q == 32'd0) ? S_FIX : S_EUC_W;
				end
				S_EUC_W: if (rsp.done) begin
					r0_q <= r1_q;
					r1_q <= rsp.remainder;
					t0_q <= t1_q;
					t1_q <= 34'(t0_q - qt);
					state_q <= S_EUC;
				end
				S_FIX: begin
					if (r0_q != 32'd1) begin
						out_ch.data.status <= rkr_pkg::ST_NOINVERSE;
						state_q <= S_OUT;
					end else begin
						expo_q <= t0_q[33] ? 32'(t0_q + $signed({2'b0, tot_q}))
							: t0_q[31:0];
						state_q <= S_PBASE;
					end
				end
				S_PBASE: begin
					acc_q <= (n_q == 32'd1) ? 32'd0 : 32'd1;
					state_q <= S_PBASE_W;
				end
				S_PBASE_W: if (rsp.done) begin
					base_q <= rsp.remainder;
					state_q <= S_PMUL;
				end
				S_PMUL: begin
					if (expo_q == 32'd0) begin
						out_ch.data.status <= rkr_pkg::ST_OK;
						out_ch.data.factor_p <= p_q;
						out_ch.data.factor_q <= q_q;
						out_ch.data.private_exponent <= 32'(t0_q[33]
							? t0_q + $signed({2'b0, tot_q}) : t0_q);
						out_ch.data.plaintext <= acc_q;
						state_q <= S_OUT;
					end else begin
						state_q <= expo_q[0] ? S_PMUL_W : S_PSQR;
					end
				end
				S_PMUL_W: if (rsp.done) begin
					acc_q <= rsp.remainder;
					state_q <= S_PSQR;
				end
				S_PSQR: state_q <= S_PSQR_W;
				S_PSQR_W: if (rsp.done) begin
					base_q <= rsp.remainder;
					expo_q <= expo_q >> 1;
					state_q <= S_PMUL;
				end
				S_OUT: begin
					// hold the result word until taken
					if (!out_ch.valid) begin
						out_ch.valid <= 1'b1;
					end else if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/rkr_checker.sv
// ----------------------------------------------------------------------------
// rkr_checker: port-level checks
// Watches the channels of the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rkr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input rkr_pkg::out_word_t out_data
);
	`ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
	`ASSERT_IMPL(a_status_code, out_valid, out_data.status <= rkr_pkg::ST_NOINVERSE)
	`ASSERT_IMPL(a_fail_zero, out_valid && out_data.status != rkr_pkg::ST_OK, out_data.factor_p == '0)
	`ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
endmodule

bind rsa_key_recovery_decrypt rkr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
